// ----- hdl/gdr_pkg.sv -----
// Shared types and constants of the grid raycaster.
// Used by the divider, datapath, controller and top level; depends on nothing.
package gdr_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAP_SIZE    = 64;
    localparam int MAP_BITS    = 6;
    localparam int MAP_CELLS   = MAP_SIZE * MAP_SIZE;
    localparam int MAX_SCREEN  = 1024;
    localparam int MAX_STEPS_D = 128;

    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;

    localparam int CFG_DW = 22;
    localparam int CFG_AW = 4;

    localparam logic [23:0] DIST_MAX = 24'hFF_FFFF;

    typedef enum logic [CFG_AW-1:0] {
        REG_POS_X   = 4'd0,
        REG_POS_Y   = 4'd1,
        REG_DIR_X   = 4'd2,
        REG_DIR_Y   = 4'd3,
        REG_PLANE_X = 4'd4,
        REG_PLANE_Y = 4'd5,
        REG_WIDTH   = 4'd6,
        REG_HEIGHT  = 4'd7
    } t_reg_idx;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_CAM_GO, ST_CAM_WT, ST_RAY_MUL, ST_RAY_ADD,
        ST_DX_GO, ST_DX_WT, ST_DY_GO, ST_DY_WT, ST_SIDE, ST_STEP, ST_CHECK,
        ST_NUM, ST_DIST_GO, ST_DIST_WT, ST_FRAC_MUL, ST_FRAC_ADD,
        ST_LH_GO, ST_LH_WT, ST_HIT, ST_MISS
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_ACCEPT, OP_CAM_GO, OP_CAM_LD, OP_RAY_MUL,
        OP_RAY_ADD, OP_DX_GO, OP_DX_LD, OP_DY_GO, OP_DY_LD, OP_SIDE, OP_STEP,
        OP_NUM, OP_DIST_GO, OP_DIST_LD, OP_DIST_MAX, OP_FRAC_MUL, OP_FRAC_ADD,
        OP_LH_GO, OP_LH_LD, OP_LH_MAX, OP_OUT_HIT, OP_OUT_MISS
    } t_op;

    typedef struct packed {
        t_op  op;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_valid;
        logic in_cast;
        logic div_done;
        logic in_map;
        logic wall;
        logic limit;
        logic r_zero;
        logic dist_zero;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/gdr_divider.sv -----
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on gdr_pkg for the operand widths.
module gdr_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [gdr_pkg::DIV_NW-1:0] i_dividend,
    input  logic [gdr_pkg::DIV_DW-1:0] i_divisor,
    output logic                       o_done,
    output logic [gdr_pkg::DIV_NW-1:0] o_quotient
);
    localparam int NW = gdr_pkg::DIV_NW;
    localparam int DW = gdr_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem, r_div;
    logic [DW:0]   trial, diff;
    logic          ge;

    assign trial = {r_rem, r_q[NW-1]};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ----- hdl/gdr_datapath.sv -----
// Datapath of the raycaster: configuration registers, wall map, DDA registers,
// the shared divider and the output register. Depends on gdr_pkg, gdr_divider.
module gdr_datapath #(
    parameter int MAX_STEPS = gdr_pkg::MAX_STEPS_D
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gdr_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [gdr_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                       s_axis_tvalid,
    input  logic [23:0]                s_axis_tdata,
    input  logic [0:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [71:0]                m_axis_tdata,
    output logic [0:0]                 m_axis_tuser,
    input  gdr_pkg::t_cmd              i_cmd,
    output gdr_pkg::t_status           o_sts
);
    localparam int F   = gdr_pkg::FRAC_BITS;
    localparam int SCW = $clog2(MAX_STEPS + 1);
    localparam int MAW = 2 * gdr_pkg::MAP_BITS;
    localparam logic [36:0] DELTA_CAP = 37'd1 << 36;
    localparam logic [50:0] LH_CAP    = 51'd1 << 50;

    // configuration
    logic [21:0]        r_pos_x, r_pos_y;
    logic signed [18:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [10:0]        r_scr_w, r_scr_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= 22'd98304;
            r_pos_y   <= 22'd98304;
            r_dir_x   <= -19'sd65536;
            r_dir_y   <= 19'sd0;
            r_plane_x <= 19'sd0;
            r_plane_y <= 19'sd43254;
            r_scr_w   <= 11'd640;
            r_scr_h   <= 11'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gdr_pkg::REG_POS_X:   r_pos_x   <= i_cfg_data;
                gdr_pkg::REG_POS_Y:   r_pos_y   <= i_cfg_data;
                gdr_pkg::REG_DIR_X:   r_dir_x   <= i_cfg_data[18:0];
                gdr_pkg::REG_DIR_Y:   r_dir_y   <= i_cfg_data[18:0];
                gdr_pkg::REG_PLANE_X: r_plane_x <= i_cfg_data[18:0];
                gdr_pkg::REG_PLANE_Y: r_plane_y <= i_cfg_data[18:0];
                gdr_pkg::REG_WIDTH:   r_scr_w   <= i_cfg_data[10:0];
                gdr_pkg::REG_HEIGHT:  r_scr_h   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    logic [10:0] scr_w, scr_h;
    assign scr_w = (r_scr_w == '0) ? 11'd1 :
                   (r_scr_w > 11'(gdr_pkg::MAX_SCREEN)) ? 11'(gdr_pkg::MAX_SCREEN) : r_scr_w;
    assign scr_h = (r_scr_h == '0) ? 11'd1 :
                   (r_scr_h > 11'(gdr_pkg::MAX_SCREEN)) ? 11'(gdr_pkg::MAX_SCREEN) : r_scr_h;

    logic accept;
    assign accept = i_cmd.in_ready && s_axis_tvalid;

    // ray registers
    logic [9:0]           r_col;
    logic signed [28:0]   r_camx;
    logic signed [47:0]   r_px, r_py;
    logic signed [32:0]   r_rx, r_ry;
    logic [36:0]          r_dx, r_dy;
    logic [47:0]          r_sx, r_sy;
    logic [7:0]           r_mx, r_my;
    logic [1:0]           r_side;
    logic [SCW-1:0]       r_n;
    logic                 r_rd, r_inmap;
    logic [23:0]          r_nmag;
    logic                 r_rzero;
    logic [23:0]          r_dist;
    logic signed [57:0]   r_fprod;
    logic [15:0]          r_frac;
    logic [50:0]          r_lh;
    logic [MAW-1:0]       r_clr;

    logic [32:0] rx_abs, ry_abs;
    assign rx_abs = r_rx[32] ? 33'(-r_rx) : 33'(r_rx);
    assign ry_abs = r_ry[32] ? 33'(-r_ry) : 33'(r_ry);

    // divider operands
    logic                       div_start, div_done;
    logic [gdr_pkg::DIV_NW-1:0] div_n, quo;
    logic [gdr_pkg::DIV_DW-1:0] div_d;

    always_comb begin
        div_start = 1'b1;
        div_n     = '0;
        div_d     = '0;
        case (i_cmd.op)
            gdr_pkg::OP_CAM_GO: begin
                div_n = gdr_pkg::DIV_NW'({r_col, 17'd0});
                div_d = gdr_pkg::DIV_DW'(scr_w);
            end
            gdr_pkg::OP_DX_GO: begin
                div_n = gdr_pkg::DIV_NW'(1) << (2 * F);
                div_d = rx_abs[31:0];
            end
            gdr_pkg::OP_DY_GO: begin
                div_n = gdr_pkg::DIV_NW'(1) << (2 * F);
                div_d = ry_abs[31:0];
            end
            gdr_pkg::OP_DIST_GO: begin
                div_n = gdr_pkg::DIV_NW'({r_nmag, 16'd0});
                div_d = (r_side[1] == 1'b0) ? rx_abs[31:0] : ry_abs[31:0];
            end
            gdr_pkg::OP_LH_GO: begin
                div_n = gdr_pkg::DIV_NW'({scr_h, 32'd0});
                div_d = gdr_pkg::DIV_DW'(r_dist);
            end
            default: div_start = 1'b0;
        endcase
    end

    gdr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // initial side distances
    logic [16:0] fx, fy;
    logic [49:0] sprod_x, sprod_y;
    assign fx = r_rx[32] ? {1'b0, r_pos_x[15:0]} : 17'd65536 - {1'b0, r_pos_x[15:0]};
    assign fy = r_ry[32] ? {1'b0, r_pos_y[15:0]} : 17'd65536 - {1'b0, r_pos_y[15:0]};
    assign sprod_x = fx * r_dx[32:0];
    assign sprod_y = fy * r_dy[32:0];

    // one DDA step
    logic        take_x;
    logic [7:0]  n_mx, n_my;
    logic        n_inmap;
    assign take_x  = r_sx < r_sy;
    assign n_mx    = (i_cmd.op == gdr_pkg::OP_STEP && take_x) ?
                     r_mx + (r_rx[32] ? 8'hFF : 8'h01) : r_mx;
    assign n_my    = (i_cmd.op == gdr_pkg::OP_STEP && !take_x) ?
                     r_my + (r_ry[32] ? 8'hFF : 8'h01) : r_my;
    assign n_inmap = (n_mx < 8'(gdr_pkg::MAP_SIZE)) && (n_my < 8'(gdr_pkg::MAP_SIZE));

    // distance numerator on the axis of the last step
    logic [24:0] num;
    always_comb begin
        if (r_side[1] == 1'b0)
            num = 25'({r_mx[5:0], 16'd0}) + (r_rx[32] ? 25'd65536 : 25'd0) - 25'(r_pos_x);
        else
            num = 25'({r_my[5:0], 16'd0}) + (r_ry[32] ? 25'd65536 : 25'd0) - 25'(r_pos_y);
    end

    // row span
    logic [51:0] half, lhh, s_val, e_val;
    logic [35:0] e_int;
    logic [9:0]  d_start, d_end;
    assign half    = 52'({scr_h[10:1], 16'd0});
    assign lhh     = 52'(r_lh[50:1]);
    assign s_val   = half - lhh;
    assign e_val   = half + lhh;
    assign e_int   = e_val[51:16];
    assign d_start = (!s_val[51] && s_val != '0) ? s_val[25:16] : 10'd0;
    assign d_end   = (e_int >= 36'(scr_h)) ? 10'(scr_h - 11'd1) : e_int[9:0];

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            gdr_pkg::OP_ACCEPT:  if (accept) r_col <= s_axis_tdata[9:0];
            gdr_pkg::OP_CAM_LD:  r_camx <= $signed({1'b0, quo[27:0]}) - 29'sd65536;
            gdr_pkg::OP_RAY_MUL: begin
                r_px <= r_plane_x * r_camx;
                r_py <= r_plane_y * r_camx;
            end
            gdr_pkg::OP_RAY_ADD: begin
                r_rx <= 33'(r_dir_x) + 33'($signed(r_px[47:16]));
                r_ry <= 33'(r_dir_y) + 33'($signed(r_py[47:16]));
                r_mx <= {2'b00, r_pos_x[21:16]};
                r_my <= {2'b00, r_pos_y[21:16]};
                r_n  <= '0;
            end
            gdr_pkg::OP_DX_LD: r_dx <= (r_rx == '0) ? DELTA_CAP : 37'(quo[32:0]);
            gdr_pkg::OP_DY_LD: r_dy <= (r_ry == '0) ? DELTA_CAP : 37'(quo[32:0]);
            gdr_pkg::OP_SIDE: begin
                r_sx <= r_dx[36] ? 48'({fx, 20'd0}) : 48'(sprod_x[49:16]);
                r_sy <= r_dy[36] ? 48'({fy, 20'd0}) : 48'(sprod_y[49:16]);
            end
            gdr_pkg::OP_STEP: begin
                if (take_x) begin
                    r_sx   <= r_sx + 48'(r_dx);
                    r_side <= (!r_rx[32] && r_rx != '0) ? 2'd0 : 2'd1;
                end else begin
                    r_sy   <= r_sy + 48'(r_dy);
                    r_side <= (!r_ry[32] && r_ry != '0) ? 2'd2 : 2'd3;
                end
                r_mx    <= n_mx;
                r_my    <= n_my;
                r_inmap <= n_inmap;
                r_n     <= r_n + 1'b1;
            end
            gdr_pkg::OP_NUM: begin
                r_nmag  <= num[24] ? 24'(-num) : num[23:0];
                r_rzero <= (r_side[1] == 1'b0) ? (r_rx == '0) : (r_ry == '0);
            end
            gdr_pkg::OP_DIST_LD:
                r_dist <= (quo > gdr_pkg::DIV_NW'(gdr_pkg::DIST_MAX)) ? gdr_pkg::DIST_MAX
                                                                      : quo[23:0];
            gdr_pkg::OP_DIST_MAX: r_dist <= gdr_pkg::DIST_MAX;
            gdr_pkg::OP_FRAC_MUL:
                r_fprod <= $signed({1'b0, r_dist}) * ((r_side[1] == 1'b0) ? r_ry : r_rx);
            gdr_pkg::OP_FRAC_ADD:
                r_frac <= ((r_side[1] == 1'b0) ? r_pos_y[15:0] : r_pos_x[15:0])
                          + r_fprod[31:16];
            gdr_pkg::OP_LH_LD:  r_lh <= 51'(quo[42:0]);
            gdr_pkg::OP_LH_MAX: r_lh <= LH_CAP;
            default: ;
        endcase
    end

    // wall map, one write port and one registered read port
    logic r_map [gdr_pkg::MAP_CELLS];
    logic           map_we, map_wd;
    logic [MAW-1:0] map_wa;

    always_comb begin
        map_we = 1'b0;
        map_wa = r_clr;
        map_wd = 1'b0;
        if (i_cmd.op == gdr_pkg::OP_CLEAR) begin
            map_we = 1'b1;
        end else if (accept && !s_axis_tuser[0]) begin
            map_we = 1'b1;
            map_wa = {s_axis_tdata[15:10], s_axis_tdata[21:16]};
            map_wd = s_axis_tdata[22];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) r_map[map_wa] <= map_wd;
        r_rd <= r_map[{n_mx[5:0], n_my[5:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= '0;
        else if (i_cmd.op == gdr_pkg::OP_CLEAR) r_clr <= r_clr + 1'b1;
    end

    // output register
    logic r_ovalid;
    logic [71:0] r_odata;
    logic r_onohit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == gdr_pkg::OP_OUT_HIT || i_cmd.op == gdr_pkg::OP_OUT_MISS) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == gdr_pkg::OP_OUT_HIT) begin
            r_odata  <= {d_end, d_start, r_frac, r_dist, r_side, r_col};
            r_onohit <= 1'b0;
        end else if (i_cmd.op == gdr_pkg::OP_OUT_MISS) begin
            r_odata  <= {10'd0, 10'd0, 16'd0, gdr_pkg::DIST_MAX, 2'd0, r_col};
            r_onohit <= 1'b1;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_onohit;

    assign o_sts.clr_done  = (r_clr == '1);
    assign o_sts.in_valid  = s_axis_tvalid;
    assign o_sts.in_cast   = s_axis_tuser[0];
    assign o_sts.div_done  = div_done;
    assign o_sts.in_map    = r_inmap;
    assign o_sts.wall      = r_rd;
    assign o_sts.limit     = (r_n == SCW'(MAX_STEPS));
    assign o_sts.r_zero    = r_rzero;
    assign o_sts.dist_zero = (r_dist == '0);
    assign o_sts.out_free  = !r_ovalid || m_axis_tready;

endmodule

// ----- hdl/gdr_ctrl.sv -----
// Controller of the raycaster: sequences map clearing, ray setup, DDA steps
// and the final divisions. Depends on gdr_pkg.
module gdr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gdr_pkg::t_status i_sts,
    output gdr_pkg::t_cmd    o_cmd
);
    gdr_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gdr_pkg::ST_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gdr_pkg::ST_CLEAR:    if (i_sts.clr_done) n_state = gdr_pkg::ST_IDLE;
            gdr_pkg::ST_IDLE:     if (i_sts.in_valid && i_sts.in_cast)
                                      n_state = gdr_pkg::ST_CAM_GO;
            gdr_pkg::ST_CAM_GO:   n_state = gdr_pkg::ST_CAM_WT;
            gdr_pkg::ST_CAM_WT:   if (i_sts.div_done) n_state = gdr_pkg::ST_RAY_MUL;
            gdr_pkg::ST_RAY_MUL:  n_state = gdr_pkg::ST_RAY_ADD;
            gdr_pkg::ST_RAY_ADD:  n_state = gdr_pkg::ST_DX_GO;
            gdr_pkg::ST_DX_GO:    n_state = gdr_pkg::ST_DX_WT;
            gdr_pkg::ST_DX_WT:    if (i_sts.div_done) n_state = gdr_pkg::ST_DY_GO;
            gdr_pkg::ST_DY_GO:    n_state = gdr_pkg::ST_DY_WT;
            gdr_pkg::ST_DY_WT:    if (i_sts.div_done) n_state = gdr_pkg::ST_SIDE;
            gdr_pkg::ST_SIDE:     n_state = gdr_pkg::ST_STEP;
            gdr_pkg::ST_STEP:     n_state = gdr_pkg::ST_CHECK;
            gdr_pkg::ST_CHECK: begin
                if (!i_sts.in_map)    n_state = gdr_pkg::ST_MISS;
                else if (i_sts.wall)  n_state = gdr_pkg::ST_NUM;
                else if (i_sts.limit) n_state = gdr_pkg::ST_MISS;
                else                  n_state = gdr_pkg::ST_STEP;
            end
            gdr_pkg::ST_NUM:      n_state = gdr_pkg::ST_DIST_GO;
            gdr_pkg::ST_DIST_GO:  n_state = i_sts.r_zero ? gdr_pkg::ST_FRAC_MUL
                                                         : gdr_pkg::ST_DIST_WT;
            gdr_pkg::ST_DIST_WT:  if (i_sts.div_done) n_state = gdr_pkg::ST_FRAC_MUL;
            gdr_pkg::ST_FRAC_MUL: n_state = gdr_pkg::ST_FRAC_ADD;
            gdr_pkg::ST_FRAC_ADD: n_state = gdr_pkg::ST_LH_GO;
            gdr_pkg::ST_LH_GO:    n_state = i_sts.dist_zero ? gdr_pkg::ST_HIT
                                                            : gdr_pkg::ST_LH_WT;
            gdr_pkg::ST_LH_WT:    if (i_sts.div_done) n_state = gdr_pkg::ST_HIT;
            gdr_pkg::ST_HIT,
            gdr_pkg::ST_MISS:     if (i_sts.out_free) n_state = gdr_pkg::ST_IDLE;
            default:              n_state = gdr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op       = gdr_pkg::OP_NONE;
        o_cmd.in_ready = 1'b0;
        case (r_state)
            gdr_pkg::ST_CLEAR:    o_cmd.op = gdr_pkg::OP_CLEAR;
            gdr_pkg::ST_IDLE: begin
                o_cmd.op       = gdr_pkg::OP_ACCEPT;
                o_cmd.in_ready = 1'b1;
            end
            gdr_pkg::ST_CAM_GO:   o_cmd.op = gdr_pkg::OP_CAM_GO;
            gdr_pkg::ST_CAM_WT:   if (i_sts.div_done) o_cmd.op = gdr_pkg::OP_CAM_LD;
            gdr_pkg::ST_RAY_MUL:  o_cmd.op = gdr_pkg::OP_RAY_MUL;
            gdr_pkg::ST_RAY_ADD:  o_cmd.op = gdr_pkg::OP_RAY_ADD;
            gdr_pkg::ST_DX_GO:    o_cmd.op = gdr_pkg::OP_DX_GO;
            gdr_pkg::ST_DX_WT:    if (i_sts.div_done) o_cmd.op = gdr_pkg::OP_DX_LD;
            gdr_pkg::ST_DY_GO:    o_cmd.op = gdr_pkg::OP_DY_GO;
            gdr_pkg::ST_DY_WT:    if (i_sts.div_done) o_cmd.op = gdr_pkg::OP_DY_LD;
            gdr_pkg::ST_SIDE:     o_cmd.op = gdr_pkg::OP_SIDE;
            gdr_pkg::ST_STEP:     o_cmd.op = gdr_pkg::OP_STEP;
            gdr_pkg::ST_NUM:      o_cmd.op = gdr_pkg::OP_NUM;
            gdr_pkg::ST_DIST_GO:  o_cmd.op = i_sts.r_zero ? gdr_pkg::OP_DIST_MAX
                                                          : gdr_pkg::OP_DIST_GO;
            gdr_pkg::ST_DIST_WT:  if (i_sts.div_done) o_cmd.op = gdr_pkg::OP_DIST_LD;
            gdr_pkg::ST_FRAC_MUL: o_cmd.op = gdr_pkg::OP_FRAC_MUL;
            gdr_pkg::ST_FRAC_ADD: o_cmd.op = gdr_pkg::OP_FRAC_ADD;
            gdr_pkg::ST_LH_GO:    o_cmd.op = i_sts.dist_zero ? gdr_pkg::OP_LH_MAX
                                                             : gdr_pkg::OP_LH_GO;
            gdr_pkg::ST_LH_WT:    if (i_sts.div_done) o_cmd.op = gdr_pkg::OP_LH_LD;
            gdr_pkg::ST_HIT:      if (i_sts.out_free) o_cmd.op = gdr_pkg::OP_OUT_HIT;
            gdr_pkg::ST_MISS:     if (i_sts.out_free) o_cmd.op = gdr_pkg::OP_OUT_MISS;
            default: ;
        endcase
    end

    // A divider result only arrives while a wait state expects it.
    a_div_done_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == gdr_pkg::ST_CAM_WT || r_state == gdr_pkg::ST_DX_WT ||
                            r_state == gdr_pkg::ST_DY_WT || r_state == gdr_pkg::ST_DIST_WT ||
                            r_state == gdr_pkg::ST_LH_WT))
        else $error("divider finished outside a wait state");

    // Every step is followed by its map lookup.
    a_step_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gdr_pkg::ST_STEP |=> r_state == gdr_pkg::ST_CHECK)
        else $error("DDA step not followed by its check");

    // A result is loaded only when the output register can take it.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == gdr_pkg::OP_OUT_HIT || o_cmd.op == gdr_pkg::OP_OUT_MISS)
        |-> i_sts.out_free)
        else $error("result loaded over a waiting beat");

endmodule

// ----- hdl/grid_dda_raycaster_unit.sv -----
// Top level of the grid DDA raycaster.
// Depends on gdr_pkg, gdr_ctrl and gdr_datapath (which holds gdr_divider).
//
// Each input beat either writes one wall bit of the 64x64 map (tuser 0) or
// casts the ray of one screen column (tuser 1). A cast runs its divisions on
// one shared radix-2 divider that makes one quotient bit per cycle for a
// 48-bit quotient. A hit runs up to five divisions: camera x, both delta
// distances, wall distance and line height. A DDA step has a STEP and a CHECK
// state because the map lookup is registered. A miss skips the last two
// divisions. After reset the map is cleared one cell a cycle, all 4096 cells,
// before the first beat is taken. Configuration writes are taken at any time.
// A finished result sits in the output register while the next beat is
// accepted.
module grid_dda_raycaster_unit #(
    parameter int MAX_STEPS = gdr_pkg::MAX_STEPS_D
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gdr_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [gdr_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // column[9:0], cell_x[15:10], cell_y[21:16], cell_is_wall[22], zero[23]
    input  logic [23:0]                s_axis_tdata,
    // operation[0]
    input  logic [0:0]                 s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // result_column[9:0], wall_side[11:10], wall_distance[35:12],
    // wall_fraction[51:36], draw_start[61:52], draw_end[71:62]
    output logic [71:0]                m_axis_tdata,
    // no_hit[0]
    output logic [0:0]                 m_axis_tuser
);
    gdr_pkg::t_cmd    cmd;
    gdr_pkg::t_status sts;

    gdr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    gdr_datapath #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

    assign s_axis_tready = cmd.in_ready;

endmodule
